// ===== hw/rtl/hrfd_pkg.sv =====
// Shared types, character codes and constants for the HTTP request framing detector.
package hrfd_pkg;

  localparam int LEN_W   = 32;   // width of a parsed body length
  localparam int COUNT_W = 24;   // width of the byte counters and the limit

  localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] MAX_REQ_RESET  = COUNT_W'(1048576);

  localparam logic [3:0] KEY_LEN = 4'd14;

  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_CLOSED   = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    PH_NAME_LEAD  = 7'b0000001,
    PH_NAME       = 7'b0000010,
    PH_NAME_TRAIL = 7'b0000100,
    PH_VAL_LEAD   = 7'b0001000,
    PH_VAL_DIGITS = 7'b0010000,
    PH_VAL_TRAIL  = 7'b0100000,
    PH_SKIP       = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic ovf;
    logic bad;
    logic digit;
  } value_flags_t;

  // Header parser to frame tracker: end of header and current body length.
  typedef struct packed {
    logic             hdr_end;
    logic [LEN_W-1:0] length;
  } hdr_info_t;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   content_length;
    logic [COUNT_W-1:0] request_bytes;
    logic [COUNT_W-1:0] header_bytes;
  } result_t;

  // Characters of the header name "Content-Length".
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/hrfd_hdr_parser.sv =====
// Header line parser: blank-line detection, Content-Length name match and value decode.
module hrfd_hdr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                clear,
  input  logic [7:0]          data_byte,
  output hrfd_pkg::hdr_info_t info
);
  import hrfd_pkg::*;

  logic [23:0]      recent_bytes, recent_bytes_next;
  phase_t           line_phase, line_phase_next;
  logic [3:0]       name_match_index, name_match_index_next;
  logic             name_still_matches, name_still_matches_next;
  logic [LEN_W-1:0] value_accumulator, value_accumulator_next;
  value_flags_t     value_flags, value_flags_next;
  logic             length_found, length_found_next;
  logic [LEN_W-1:0] length_value, length_value_next;

  logic             is_blank, is_digit, in_value, hdr_end;
  logic [3:0]       digit;
  logic [LEN_W+3:0] acc_ext, acc_times_ten;

  assign is_blank = (data_byte == CHR_SP) || (data_byte == CHR_TAB);
  assign is_digit = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
  assign digit    = 4'(data_byte - CHR_ZERO);
  assign in_value = (line_phase == PH_VAL_LEAD) || (line_phase == PH_VAL_DIGITS) ||
                    (line_phase == PH_VAL_TRAIL);

  // acc * 10 + digit as two shifted adds; the top bits flag overflow
  assign acc_ext       = (LEN_W+4)'(value_accumulator);
  assign acc_times_ten = (acc_ext << 3) + (acc_ext << 1) + (LEN_W+4)'(digit);

  always_comb begin
    recent_bytes_next       = recent_bytes;
    line_phase_next         = line_phase;
    name_match_index_next   = name_match_index;
    name_still_matches_next = name_still_matches;
    value_accumulator_next  = value_accumulator;
    value_flags_next        = value_flags;
    length_found_next       = length_found;
    length_value_next       = length_value;
    hdr_end                 = 1'b0;
    if (step) begin
      hdr_end = (data_byte == CHR_LF) &&
                ((recent_bytes[7:0] == CHR_LF) ||
                 ((recent_bytes[7:0] == CHR_CR) && (recent_bytes[15:8] == CHR_LF) &&
                  (recent_bytes[23:16] == CHR_CR)));
      recent_bytes_next = {recent_bytes[15:0], data_byte};
      if (data_byte == CHR_LF) begin
        // end of line: latch the first Content-Length value
        if (in_value) begin
          length_found_next = 1'b1;
          length_value_next = (value_flags.digit && !value_flags.bad && !value_flags.ovf) ?
                              value_accumulator : '0;
        end
        line_phase_next         = PH_NAME_LEAD;
        name_match_index_next   = 4'd0;
        name_still_matches_next = 1'b1;
        value_accumulator_next  = '0;
        value_flags_next        = '0;
      end else begin
        unique case (line_phase)
          PH_NAME_LEAD, PH_NAME, PH_NAME_TRAIL: begin
            if (!((line_phase == PH_NAME_LEAD) && is_blank)) begin
              line_phase_next = (line_phase == PH_NAME_LEAD) ? PH_NAME : line_phase;
              if (data_byte == CHR_COLON) begin
                line_phase_next = (name_still_matches && (name_match_index == KEY_LEN) &&
                                   !length_found) ? PH_VAL_LEAD : PH_SKIP;
              end else if (is_blank || (data_byte == CHR_CR)) begin
                line_phase_next = PH_NAME_TRAIL;
              end else if (line_phase == PH_NAME_TRAIL) begin
                // text after inner blank: name cannot match
                name_still_matches_next = 1'b0;
                line_phase_next         = PH_NAME;
              end else if ((name_match_index < KEY_LEN) &&
                           (data_byte == key_char(name_match_index))) begin
                name_match_index_next = name_match_index + 4'd1;
              end else begin
                name_still_matches_next = 1'b0;
              end
            end
          end
          PH_VAL_LEAD: begin
            if (!is_blank) begin
              if (is_digit) begin
                value_accumulator_next = LEN_W'(digit);
                value_flags_next.digit = 1'b1;
                line_phase_next        = PH_VAL_DIGITS;
              end else begin
                value_flags_next.bad = 1'b1;
                line_phase_next      = PH_VAL_TRAIL;
              end
            end
          end
          PH_VAL_DIGITS: begin
            if (is_digit) begin
              if (!value_flags.ovf) begin
                if (acc_times_ten[LEN_W+3:LEN_W] != 4'd0) begin
                  value_flags_next.ovf = 1'b1;
                end else begin
                  value_accumulator_next = acc_times_ten[LEN_W-1:0];
                end
              end
            end else if (is_blank || (data_byte == CHR_CR)) begin
              line_phase_next = PH_VAL_TRAIL;
            end else begin
              value_flags_next.bad = 1'b1;
            end
          end
          PH_VAL_TRAIL: begin
            if (!is_blank && (data_byte != CHR_CR)) begin
              value_flags_next.bad = 1'b1;
            end
          end
          PH_SKIP: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign info.hdr_end = hdr_end;
  assign info.length  = length_value_next;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      recent_bytes       <= '0;
      line_phase         <= PH_NAME_LEAD;
      name_match_index   <= 4'd0;
      name_still_matches <= 1'b1;
      value_accumulator  <= '0;
      value_flags        <= '0;
      length_found       <= 1'b0;
      length_value       <= '0;
    end else if (step) begin
      recent_bytes       <= recent_bytes_next;
      line_phase         <= line_phase_next;
      name_match_index   <= name_match_index_next;
      name_still_matches <= name_still_matches_next;
      value_accumulator  <= value_accumulator_next;
      value_flags        <= value_flags_next;
      length_found       <= length_found_next;
      length_value       <= length_value_next;
    end
  end

endmodule

// ===== hw/rtl/hrfd_frame_tracker.sv =====
// Request framing: byte, header and body counters, status and end-of-request clear.
module hrfd_frame_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic                                op,
  input  logic [hrfd_pkg::COUNT_W-1:0]        max_request_bytes,
  input  hrfd_pkg::hdr_info_t                 hdr,
  output logic                                parse_step,
  output logic                                clear,
  output hrfd_pkg::result_t                   res
);
  import hrfd_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic               in_body, in_body_next;
  logic [COUNT_W-1:0] header_length, header_length_next;
  logic [COUNT_W-1:0] body_count, body_count_next;
  status_t            status;

  assign parse_step = fire && (op == OP_BYTE) && !in_body;

  always_comb begin
    byte_count_next    = byte_count;
    in_body_next       = in_body;
    header_length_next = header_length;
    body_count_next    = body_count;
    status             = ST_PENDING;
    if (op == OP_CLOSE) begin
      status = ST_CLOSED;
    end else begin
      if (byte_count != COUNT_MAX) begin
        byte_count_next = byte_count + COUNT_W'(1);
      end
      if (!in_body) begin
        if (hdr.hdr_end) begin
          in_body_next       = 1'b1;
          header_length_next = byte_count_next;
        end
      end else if (body_count != COUNT_MAX) begin
        body_count_next = body_count + COUNT_W'(1);
      end
      priority if (in_body_next && (LEN_W'(body_count_next) >= hdr.length)) begin
        status = ST_COMPLETE;
      end else if (byte_count_next >= max_request_bytes) begin
        status = ST_LIMIT;
      end else begin
        status = ST_PENDING;
      end
    end
  end

  assign clear              = fire && (status != ST_PENDING);
  assign res.status         = status;
  assign res.content_length = in_body_next ? hdr.length : '0;
  assign res.request_bytes  = byte_count_next;
  assign res.header_bytes   = header_length_next;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_count    <= '0;
      in_body       <= 1'b0;
      header_length <= '0;
      body_count    <= '0;
    end else if (fire) begin
      byte_count    <= byte_count_next;
      in_body       <= in_body_next;
      header_length <= header_length_next;
      body_count    <= body_count_next;
    end
  end

`ifndef SYNTH
  a_body_needs_header: assert property (@(posedge clk) disable iff (rst)
    in_body |-> (header_length != '0))
    else $error("body state without a header length");

  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    clear |=> (byte_count == '0) && !in_body)
    else $error("request state not cleared after a final status");

  a_body_count_idle: assert property (@(posedge clk) disable iff (rst)
    !in_body |-> (body_count == '0))
    else $error("body bytes counted before the header end");
`endif

endmodule

// ===== hw/rtl/http_request_framing_detector_top.sv =====
// Top level of the HTTP/1.1 request framing detector with Content-Length bodies.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  item     | item_valid / item_stall    | op, data_byte
//  result   | result_valid / result_stall| status, content_length, request_bytes,
//           |                            | header_bytes
//  cfg      | cfg_valid / cfg_ready      | cfg_data (max_request_bytes)
//
// Each item transaction yields exactly one result transaction, held first in the input
// register and then in the result register. One item is taken every cycle while
// item_stall is low; the per-byte parser state loop closes between the input
// register and the result register.
// Reset (rst, synchronous) clears the request state and loads the byte limit 1048576.
// A result stall holds the result register and, once the input register is full, raises
// item_stall in the same cycle; no transaction is dropped.
module http_request_framing_detector_top (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              op,
  input  logic [7:0]                        data_byte,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output hrfd_pkg::status_t                 status,
  output logic [hrfd_pkg::LEN_W-1:0]        content_length,
  output logic [hrfd_pkg::COUNT_W-1:0]      request_bytes,
  output logic [hrfd_pkg::COUNT_W-1:0]      header_bytes,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hrfd_pkg::COUNT_W-1:0]      cfg_data
);
  import hrfd_pkg::*;

  // byte limit register
  logic [COUNT_W-1:0] max_request_bytes;

  // input register
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;

  logic       advance;
  logic       fire;
  logic       parse_step;
  logic       clear;
  hdr_info_t  hdr;
  result_t    res;

  // Writes must land only while idle; the block does not enforce it and takes them at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_request_bytes <= MAX_REQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_request_bytes <= cfg_data;
    end
  end

  // Advance when the result register is empty or being drained.
  assign advance    = !result_valid || !result_stall;
  assign fire       = in_valid && advance;
  assign item_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  // Hold the payload while stalled; capture a fresh transaction otherwise.
  always_ff @(posedge clk) begin
    if (!item_stall) begin
      in_op   <= op;
      in_byte <= data_byte;
    end
  end

  hrfd_hdr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (parse_step),
    .clear     (clear),
    .data_byte (in_byte),
    .info      (hdr)
  );

  hrfd_frame_tracker u_tracker (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .op                (in_op),
    .max_request_bytes (max_request_bytes),
    .hdr               (hdr),
    .parse_step        (parse_step),
    .clear             (clear),
    .res               (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= res.status;
      content_length <= res.content_length;
      request_bytes  <= res.request_bytes;
      header_bytes   <= res.header_bytes;
    end
  end

`ifndef SYNTH
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("processed transaction did not reach the result register");

  a_header_within_request: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (header_bytes != '0)) |-> (header_bytes <= request_bytes))
    else $error("header length exceeds request length");

  a_complete_has_header: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == ST_COMPLETE)) |-> (header_bytes != '0))
    else $error("request complete before the header end");

  a_length_after_header: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (content_length != '0)) |-> (header_bytes != '0))
    else $error("body length reported before the header end");
`endif

endmodule
